[sv/i2c_wbr_pkg.sv]
// Package of types, codes and reset values for the I2C write / burst read master.
`timescale 1ns / 1ps
`default_nettype none

package i2c_wbr_pkg;

   // Command codes carried in the op field of a request transfer
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_TICKS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_START_REG = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_LENGTH    = 2'd2;
   localparam int unsigned CSR_DATA_W = 8;

   // Register values after reset
   localparam logic [7:0] DELAY_TICKS_RESET     = 8'd5;
   localparam logic [7:0] BURST_START_REG_RESET = 8'h32;
   localparam logic [4:0] BURST_LENGTH_RESET    = 5'd6;

   // Longest burst that the byte counter can index
   localparam logic [4:0] BURST_MAX = 5'd16;

   // Bus sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_RS   = 4'd1,
      PH_SA   = 4'd2,
      PH_SB   = 4'd3,
      PH_SC   = 4'd4,
      PH_TXL  = 4'd5,
      PH_TXH  = 4'd6,
      PH_TAL  = 4'd7,
      PH_TAH  = 4'd8,
      PH_RXL  = 4'd9,
      PH_RXH  = 4'd10,
      PH_RAL  = 4'd11,
      PH_RAH  = 4'd12,
      PH_PA   = 4'd13,
      PH_PB   = 4'd14,
      PH_PC   = 4'd15
   } phase_type;

   // Command held for the length of one transaction
   typedef struct packed {
      logic       rd;
      logic [7:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
   } cmd_type;

   // One tick of the sequencer
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      logic       sda_in;
   } req_type;

   // Line levels and status for one tick
   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_oe;
      logic       busy_res;
      logic       done_res;
      logic       rd_valid;
      logic [3:0] rd_index;
      logic [7:0] rd_data;
      logic       nak_seen;
   } rsp_type;

endpackage

`default_nettype wire

[sv/i2c_register_write_burst_read_core.sv]
// Tick-driven I2C master for single register writes and burst register reads.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  i2c_wbr_pkg::req_type (one bus tick)
// rsp       out        rsp_valid/rsp_ready  i2c_wbr_pkg::rsp_type (levels of that tick)
// csr       in         csr_we               csr_index, csr_wdata
//
// Each request transfer is one tick; its response appears in the next cycle from the
// output register, so one tick is taken every cycle while responses are taken.
// The sequencer step is a single pass of logic from the phase registers to that register.
// req_ready falls only while a response waits in the output register and rsp_ready is low.
// Synchronous reset returns the sequencer to idle and loads the register reset values.
module i2c_register_write_burst_read_core (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_valid,
   output logic                                       req_ready,
   input  i2c_wbr_pkg::req_type                       req_data,
   output logic                                       rsp_valid,
   input  wire                                        rsp_ready,
   output i2c_wbr_pkg::rsp_type                       rsp_data,
   input  wire                                        csr_we,
   input  wire [i2c_wbr_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire [i2c_wbr_pkg::CSR_DATA_W-1:0]          csr_wdata
);
   import i2c_wbr_pkg::*;

   // Configuration registers
   logic [7:0] delay_ticks_ff;
   logic [7:0] burst_start_reg_ff;
   logic [4:0] burst_length_ff;

   // Sequencer state
   phase_type  phase_ff, phase_in;
   logic [7:0] tick_ff, tick_in;
   logic [2:0] bit_ff, bit_in;
   logic [3:0] byte_ff, byte_in;
   logic [7:0] shift_ff, shift_in;
   cmd_type    cmd_ff, cmd_in;
   logic       nak_ff, nak_in;

   // Output register
   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;

   // State as seen after a new command is taken on this tick
   logic       start;
   phase_type  eff_phase;
   logic [7:0] eff_tick;
   logic [2:0] eff_bit;
   logic [3:0] eff_byte;
   logic [7:0] eff_shift;
   logic       eff_nak;

   logic       req_fire;
   logic [7:0] delay_eff;
   logic [4:0] burst_eff;
   logic       last_rx;
   logic       phase_end;
   logic       line_scl, line_sda, line_oe;
   logic       done, rv;
   logic [7:0] rdat;
   logic [7:0] rx_shift;

   // Byte to send for a given position in the address sequence
   function automatic logic [7:0] tx_byte(input logic [3:0] seq, input cmd_type cmd,
                                          input logic [7:0] start_reg);
      logic [7:0] result;
      if (seq == 4'd0) begin
         result = cmd.dev_addr;
      end else if (seq == 4'd1) begin
         result = cmd.rd ? start_reg : cmd.reg_addr;
      end else begin
         result = cmd.rd ? (cmd.dev_addr + 8'd1) : cmd.wr_data;
      end
      return result;
   endfunction

   // Handshake: the output register parts the two sides
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Clamped views of the configuration
   always_comb begin
      delay_eff = (delay_ticks_ff == 8'd0) ? 8'd1 : delay_ticks_ff;
      if (burst_length_ff == 5'd0) begin
         burst_eff = 5'd1;
      end else if (burst_length_ff > BURST_MAX) begin
         burst_eff = BURST_MAX;
      end else begin
         burst_eff = burst_length_ff;
      end
   end

   // A command is taken only while the sequencer is idle
   always_comb begin
      start = (phase_ff == PH_IDLE) && ((req_data.op == OP_WRITE) || (req_data.op == OP_READ));
      if (start) begin
         cmd_in    = '{rd: (req_data.op == OP_READ), dev_addr: req_data.dev_addr,
                       reg_addr: req_data.reg_addr, wr_data: req_data.wr_data};
         eff_phase = PH_SA;
         eff_tick  = 8'd0;
         eff_bit   = 3'd0;
         eff_byte  = 4'd0;
         eff_shift = 8'd0;
         eff_nak   = 1'b0;
      end else begin
         cmd_in    = cmd_ff;
         eff_phase = phase_ff;
         eff_tick  = tick_ff;
         eff_bit   = bit_ff;
         eff_byte  = byte_ff;
         eff_shift = shift_ff;
         eff_nak   = nak_ff;
      end
      last_rx   = ({1'b0, eff_byte} + 5'd1) >= burst_eff;
      phase_end = !(({1'b0, eff_tick} + 9'd1) < {1'b0, delay_eff});
      rx_shift  = {eff_shift[6:0], req_data.sda_in};
   end

   // Next state of the sequencer
   always_comb begin
      phase_in = eff_phase;
      tick_in  = eff_tick;
      bit_in   = eff_bit;
      byte_in  = eff_byte;
      shift_in = eff_shift;
      nak_in   = eff_nak;
      done     = 1'b0;
      rv       = 1'b0;
      rdat     = 8'd0;
      if (eff_phase != PH_IDLE) begin
         if (!phase_end) begin
            tick_in = eff_tick + 8'd1;
         end else begin
            tick_in = 8'd0;
            unique case (eff_phase)
               PH_IDLE: begin
               end
               PH_RS: phase_in = PH_SA;
               PH_SA: phase_in = PH_SB;
               PH_SB: phase_in = PH_SC;
               PH_SC: begin
                  shift_in = tx_byte(eff_byte, cmd_in, burst_start_reg_ff);
                  bit_in   = 3'd0;
                  phase_in = PH_TXL;
               end
               PH_TXL: phase_in = PH_TXH;
               PH_TXH: begin
                  shift_in = {eff_shift[6:0], 1'b0};
                  if (eff_bit == 3'd7) begin
                     bit_in   = 3'd0;
                     phase_in = PH_TAL;
                  end else begin
                     bit_in   = eff_bit + 3'd1;
                     phase_in = PH_TXL;
                  end
               end
               PH_TAL: phase_in = PH_TAH;
               PH_TAH: begin
                  if (req_data.sda_in) begin
                     nak_in = 1'b1;
                  end
                  // After the last address byte: receive or stop
                  if (eff_byte >= 4'd2) begin
                     if (cmd_in.rd) begin
                        byte_in  = 4'd0;
                        bit_in   = 3'd0;
                        shift_in = 8'd0;
                        phase_in = PH_RXL;
                     end else begin
                        phase_in = PH_PA;
                     end
                  end else if ((eff_byte == 4'd1) && cmd_in.rd) begin
                     byte_in  = 4'd2;
                     phase_in = PH_RS;
                  end else begin
                     byte_in  = eff_byte + 4'd1;
                     shift_in = tx_byte(eff_byte + 4'd1, cmd_in, burst_start_reg_ff);
                     bit_in   = 3'd0;
                     phase_in = PH_TXL;
                  end
               end
               PH_RXL: phase_in = PH_RXH;
               PH_RXH: begin
                  shift_in = rx_shift;
                  if (eff_bit == 3'd7) begin
                     rv       = 1'b1;
                     rdat     = rx_shift;
                     bit_in   = 3'd0;
                     phase_in = PH_RAL;
                  end else begin
                     bit_in   = eff_bit + 3'd1;
                     phase_in = PH_RXL;
                  end
               end
               PH_RAL: phase_in = PH_RAH;
               PH_RAH: begin
                  if (last_rx) begin
                     phase_in = PH_PA;
                  end else begin
                     byte_in  = eff_byte + 4'd1;
                     bit_in   = 3'd0;
                     shift_in = 8'd0;
                     phase_in = PH_RXL;
                  end
               end
               PH_PA: phase_in = PH_PB;
               PH_PB: phase_in = PH_PC;
               PH_PC: begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Line levels of the current phase
   always_comb begin
      line_scl = 1'b1;
      line_sda = 1'b1;
      line_oe  = 1'b1;
      unique case (eff_phase)
         PH_IDLE: line_oe = 1'b0;
         PH_RS:   line_scl = 1'b0;
         PH_SA: begin
         end
         PH_SB:   line_sda = 1'b0;
         PH_SC: begin
            line_scl = 1'b0;
            line_sda = 1'b0;
         end
         PH_TXL: begin
            line_scl = 1'b0;
            line_sda = eff_shift[7];
         end
         PH_TXH:  line_sda = eff_shift[7];
         PH_TAL, PH_RXL: begin
            line_scl = 1'b0;
            line_oe  = 1'b0;
         end
         PH_TAH, PH_RXH: line_oe = 1'b0;
         PH_RAL: begin
            line_scl = 1'b0;
            line_sda = last_rx;
         end
         PH_RAH:  line_sda = last_rx;
         PH_PA: begin
            line_scl = 1'b0;
            line_sda = 1'b0;
         end
         PH_PB:   line_sda = 1'b0;
         PH_PC: begin
         end
      endcase
   end

   // Response of this tick
   always_comb begin
      rsp_in.scl      = line_scl;
      rsp_in.sda_out  = line_sda;
      rsp_in.sda_oe   = line_oe;
      rsp_in.busy_res = (eff_phase != PH_IDLE);
      rsp_in.done_res = done;
      rsp_in.rd_valid = rv;
      rsp_in.rd_index = rv ? eff_byte : 4'd0;
      rsp_in.rd_data  = rdat;
      rsp_in.nak_seen = nak_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff     <= DELAY_TICKS_RESET;
         burst_start_reg_ff <= BURST_START_REG_RESET;
         burst_length_ff    <= BURST_LENGTH_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_DELAY_TICKS) begin
            delay_ticks_ff <= csr_wdata[7:0];
         end
         if (csr_index == CSR_BURST_START_REG) begin
            burst_start_reg_ff <= csr_wdata[7:0];
         end
         if (csr_index == CSR_BURST_LENGTH) begin
            burst_length_ff <= csr_wdata[4:0];
         end
      end
   end

   // Sequencer state advances once per request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= 8'd0;
         bit_ff   <= 3'd0;
         byte_ff  <= 4'd0;
         shift_ff <= 8'd0;
         cmd_ff   <= '0;
         nak_ff   <= 1'b0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         cmd_ff   <= cmd_in;
         nak_ff   <= nak_in;
      end
   end

   // Output register: loaded on a request transfer, emptied on a response transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // A received byte is only ever reported inside a transaction.
   a_rd_in_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.rd_valid) |-> rsp_ff.busy_res)
      else $error("received byte reported outside a transaction");

   // The tick that reports the stop leaves the sequencer idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && done) |=> (phase_ff == PH_IDLE))
      else $error("sequencer not idle after the stop");

   // The phase timer is at rest whenever the sequencer is idle.
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (tick_ff == 8'd0))
      else $error("phase timer running while idle");

   // A released data line always reads back as high.
   a_release_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.sda_oe) |-> rsp_ff.sda_out)
      else $error("released data line driven low");

   // With the output register empty a new tick is always taken.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request stalled with an empty output register");

endmodule

`default_nettype wire
